>>> hdl/bblc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bblc_pkg;
    localparam int Entries = 32;
    localparam int IdW = $clog2(Entries);
    localparam int CntW = $clog2(Entries + 1);
    localparam logic [31:0] CapReset = 32'd4194304;
    localparam logic [32:0] UsedMax = {33{1'b1}};

    typedef enum logic [1:0] {
        FN_USE    = 2'd0,
        FN_LOCK   = 2'd1,
        FN_UNLOCK = 2'd2,
        FN_UNLOAD = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_NOP    = 2'd0,
        ST_LOAD   = 2'd1,
        ST_OVER   = 2'd2,
        ST_UNLOAD = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_SH_RD,
        S_SH_WR,
        S_TAIL,
        S_EV_RD,
        S_EV_CHK,
        S_DROP,
        S_EV_OUT,
        S_LOAD,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> hdl/byte_budget_lru_cache_with_pins.sv
// Channel  | Direction | Handshake             | Payload
// request  | in        | i_valid / o_ready     | i_func, i_entry_id, i_entry_bytes
// result   | out       | o_valid / i_ready     | o_result_kind .. o_last
// config   | in        | i_cfg_we              | i_cfg_data (cache capacity)
//
// One request at a time; the recency list lives in a RAM with registered reads.
// Requests that leave the list alone go straight to the result; a load without
// eviction checks the budget, then writes the entry. A use hit or an unload scans
// and shifts the list. The eviction walk skips pinned entries, and each eviction
// shifts the list down behind the victim and reports it before the walk resumes.
// Reset is synchronous and clears flags, count and total; no clearing pass.
// Results wait in one output register; the sequencer stalls while it is full.
`timescale 1ns / 1ps
`default_nettype none
module byte_budget_lru_cache_with_pins
    import bblc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [4:0]  i_entry_id,
    input  wire logic [31:0] i_entry_bytes,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_result_kind,
    output logic [4:0]       o_evicted_id,
    output logic [1:0]       o_status,
    output logic [32:0]      o_used_bytes,
    output logic             o_last
);
    logic [IdW-1:0]     r_ord [Entries];
    logic [31:0]        r_size [Entries];
    logic [IdW-1:0]     r_ord_q;     // registered RAM reads
    logic [31:0]        r_size_q;
    logic [Entries-1:0] r_res, r_pin;
    logic [CntW-1:0]    r_cnt;
    logic [32:0]        r_used;
    logic [31:0]        r_cap;
    t_state             r_st, n_st;

    t_func           r_func;
    logic [IdW-1:0]  r_id;
    logic [31:0]     r_bytes;
    logic [CntW-1:0] r_pos;      // search / shift pointer
    logic [CntW-1:0] r_ev;       // eviction walk pointer
    logic [IdW-1:0]  r_victim;   // entry moved or dropped; size read address
    logic            r_evict;    // removal belongs to an eviction
    t_status         r_status;

    // RAM ports
    logic           ord_we;
    logic [IdW-1:0] ord_wa, ord_wd, ord_ra;
    logic           size_we;

    always_ff @(posedge i_clk) begin
        if (ord_we) r_ord[ord_wa] <= ord_wd;
        r_ord_q <= r_ord[ord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (size_we) r_size[r_id] <= r_bytes;
        r_size_q <= r_size[r_victim];
    end

    logic [32:0] free_sp, sum_sz, sub_sz;
    logic        fits;
    assign free_sp = ({1'b0, r_cap} > r_used) ? {1'b0, r_cap} - r_used : 33'd0;
    assign sum_sz  = (r_used > UsedMax - {1'b0, r_bytes}) ? UsedMax
                   : r_used + {1'b0, r_bytes};
    assign sub_sz  = (r_used >= {1'b0, r_size_q}) ? r_used - {1'b0, r_size_q} : 33'd0;
    assign fits    = ({1'b0, r_bytes} <= free_sp);

    logic           in_acc, id_bad, in_res;
    logic [IdW-1:0] in_id;
    assign o_ready = (r_st == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign in_id   = i_entry_id[IdW-1:0];
    assign id_bad  = (in_id == '0);
    assign in_res  = r_res[in_id];

    logic            out_free, emit, shift_end, find_hit;
    logic [CntW-1:0] pos_inc;
    assign out_free  = !o_valid || i_ready;
    assign emit      = out_free && (r_st == S_EV_OUT || r_st == S_OUT);
    assign pos_inc   = r_pos + 1'b1;
    assign shift_end = (pos_inc >= r_cnt);
    assign find_hit  = (r_ord_q == r_victim) || shift_end;

    always_comb begin
        n_st    = r_st;
        ord_we  = 1'b0;
        ord_wa  = r_pos[IdW-1:0];
        ord_wd  = r_ord_q;
        ord_ra  = r_pos[IdW-1:0];
        size_we = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (in_acc) begin
                    if (id_bad) begin
                        n_st = S_OUT;
                    end else begin
                        unique case (t_func'(i_func))
                            FN_USE:    n_st = in_res ? S_FIND_RD : S_EV_RD;
                            FN_LOCK:   n_st = in_res ? S_OUT : S_EV_RD;
                            FN_UNLOCK: n_st = S_OUT;
                            FN_UNLOAD: n_st = in_res ? S_FIND_RD : S_OUT;
                            default:   n_st = S_OUT;
                        endcase
                    end
                end
            end
            S_FIND_RD: n_st = S_FIND_CMP;
            S_FIND_CMP: n_st = find_hit ? S_SH_RD : S_FIND_RD;
            S_SH_RD: begin
                // successor read at pos+1, written back at pos next cycle
                ord_ra = pos_inc[IdW-1:0];
                if (shift_end) begin
                    n_st = (r_evict || r_func == FN_UNLOAD) ? S_DROP : S_TAIL;
                end else begin
                    n_st = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ord_we = 1'b1;
                n_st = S_SH_RD;
            end
            S_TAIL: begin
                ord_we = 1'b1;
                ord_wa = r_cnt[IdW-1:0];
                ord_wd = r_id;
                n_st = S_OUT;
            end
            S_EV_RD: begin
                ord_ra = r_ev[IdW-1:0];
                n_st = (fits || r_ev >= r_cnt) ? S_LOAD : S_EV_CHK;
            end
            S_EV_CHK: n_st = r_pin[r_ord_q] ? S_EV_RD : S_SH_RD;
            S_DROP: n_st = r_evict ? S_EV_OUT : S_OUT;
            S_EV_OUT: begin
                if (out_free) n_st = S_EV_RD;
            end
            S_LOAD: begin
                size_we = 1'b1;
                ord_we = (r_cnt < CntW'(Entries));
                ord_wa = r_cnt[IdW-1:0];
                ord_wd = r_id;
                n_st = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res   <= '0;
            r_pin   <= '0;
            r_cnt   <= '0;
            r_used  <= '0;
            r_cap   <= CapReset;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (emit) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func   <= t_func'(i_func);
                        r_id     <= in_id;
                        r_bytes  <= i_entry_bytes;
                        r_victim <= in_id;
                        r_pos    <= '0;
                        r_ev     <= '0;
                        r_evict  <= 1'b0;
                        r_status <= ST_NOP;
                        if (!id_bad) begin
                            if (t_func'(i_func) == FN_LOCK) r_pin[in_id] <= 1'b1;
                            else if (t_func'(i_func) != FN_USE) r_pin[in_id] <= 1'b0;
                        end
                    end
                end
                S_FIND_CMP: begin
                    if (!find_hit) r_pos <= pos_inc;
                end
                S_SH_RD: begin
                    if (shift_end) r_cnt <= r_cnt - 1'b1;
                end
                S_SH_WR: r_pos <= pos_inc;
                S_TAIL: r_cnt <= r_cnt + 1'b1;
                S_EV_CHK: begin
                    if (r_pin[r_ord_q]) begin
                        r_ev <= r_ev + 1'b1;
                    end else begin
                        r_victim <= r_ord_q;
                        r_pos    <= r_ev;
                        r_evict  <= 1'b1;
                    end
                end
                S_DROP: begin
                    r_used <= sub_sz;
                    r_res[r_victim] <= 1'b0;
                    r_pin[r_victim] <= 1'b0;
                    if (!r_evict) r_status <= ST_UNLOAD;
                end
                S_LOAD: begin
                    r_status <= fits ? ST_LOAD : ST_OVER;
                    r_used <= sum_sz;
                    r_res[r_id] <= 1'b1;
                    if (r_cnt < CntW'(Entries)) r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_result_kind <= (r_st == S_OUT);
            o_evicted_id  <= (r_st == S_OUT) ? 5'd0 : 5'(r_victim);
            o_status      <= (r_st == S_OUT) ? r_status : ST_UNLOAD;
            o_used_bytes  <= r_used;
            o_last        <= (r_st == S_OUT);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CntW'(Entries))
        else $error("count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_used_bytes))
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_evicted_id == 5'd0)
        else $error("completion carries id");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_status == ST_UNLOAD)
        else $error("notice status");
endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
    import bblc_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [4:0]  evicted;
        logic [1:0]  status;
        logic [32:0] used;
        logic        last;
    } t_result;

    // cache predictor and store of pending results
    class cache_scoreboard;
        logic [31:0] capacity;
        bit          resident[Entries];
        bit          pinned[Entries];
        logic [31:0] size_of[Entries];
        int          order[$];
        logic [33:0] used_total;
        t_result     pending[$];
        int          errors;

        function void clear();
            capacity = CapReset;
            foreach (resident[i]) begin
                resident[i] = 0;
                pinned[i] = 0;
                size_of[i] = 0;
            end
            order.delete();
            used_total = 0;
        endfunction

        function void push(logic kind, logic [4:0] id, t_status st);
            t_result r;
            r.kind = kind;
            r.evicted = id;
            r.status = st;
            r.used = used_total[32:0];
            r.last = kind;
            pending.push_back(r);
        endfunction

        function logic [33:0] room();
            return ({2'b0, capacity} > used_total) ? {2'b0, capacity} - used_total : 34'd0;
        endfunction

        function void drop(int id);
            used_total = (used_total >= size_of[id]) ? used_total - size_of[id] : 34'd0;
            resident[id] = 0;
            pinned[id] = 0;
            foreach (order[k])
                if (order[k] == id) begin
                    order.delete(k);
                    break;
                end
        endfunction

        function t_status load(int id, logic [31:0] bytes);
            t_status st;
            int k;
            int victim;
            st = ST_LOAD;
            k = 0;
            if (used_total + bytes > {2'b0, capacity}) begin
                while (room() < bytes && k < order.size()) begin
                    victim = order[k];
                    if (!pinned[victim]) begin
                        drop(victim);
                        push(1'b0, victim[4:0], ST_UNLOAD);
                    end else begin
                        k++;
                    end
                end
                if (room() < bytes)
                    st = ST_OVER;
            end
            used_total += bytes;
            if (used_total > UsedMax)
                used_total = UsedMax;
            resident[id] = 1;
            size_of[id] = bytes;
            order.push_back(id);
            return st;
        endfunction

        function void note_request(t_func fn, logic [4:0] id, logic [31:0] bytes);
            t_status st;
            st = ST_NOP;
            if (id != 0) begin
                case (fn)
                    FN_USE: begin
                        if (!resident[id]) begin
                            st = load(id, bytes);
                        end else begin
                            foreach (order[k])
                                if (order[k] == id) begin
                                    order.delete(k);
                                    break;
                                end
                            order.push_back(id);
                        end
                    end
                    FN_LOCK: begin
                        if (!resident[id])
                            st = load(id, bytes);
                        pinned[id] = 1;
                    end
                    FN_UNLOCK: pinned[id] = 0;
                    default: begin
                        if (resident[id]) begin
                            drop(id);
                            st = ST_UNLOAD;
                        end
                        pinned[id] = 0;
                    end
                endcase
            end
            push(1'b1, 5'd0, st);
        endfunction

        function void check(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.kind !== w.kind) begin
                $error("result_kind exp %0d got %0d", w.kind, got.kind);
                errors++;
            end
            if (got.evicted !== w.evicted) begin
                $error("evicted_id exp %0d got %0d", w.evicted, got.evicted);
                errors++;
            end
            if (got.status !== w.status) begin
                $error("status exp %0d got %0d", w.status, got.status);
                errors++;
            end
            if (got.used !== w.used) begin
                $error("used_bytes exp %0d got %0d", w.used, got.used);
                errors++;
            end
            if (got.last !== w.last) begin
                $error("last exp %0d got %0d", w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [4:0]  i_entry_id;
    logic [31:0] i_entry_bytes;
    logic        o_valid;
    logic        i_ready;
    logic        o_result_kind;
    logic [4:0]  o_evicted_id;
    logic [1:0]  o_status;
    logic [32:0] o_used_bytes;
    logic        o_last;

    cache_scoreboard sb;
    bit              stim_done;

    byte_budget_lru_cache_with_pins u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_entry_id    (i_entry_id),
        .i_entry_bytes (i_entry_bytes),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_evicted_id  (o_evicted_id),
        .o_status      (o_status),
        .o_used_bytes  (o_used_bytes),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_request(t_func fn, logic [4:0] id, logic [31:0] bytes);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_entry_id <= id;
        i_entry_bytes <= bytes;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(fn, id, bytes);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [31:0] cap);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.capacity = cap;
    endtask

    function automatic logic [31:0] rand_bytes();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    // result side: random stalls, one check per accepted result
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check({o_result_kind, o_evicted_id, o_status, o_used_bytes, o_last});
        end
    end

    initial begin
        logic [31:0] caps[4];
        sb = new();
        sb.clear();
        sb.errors = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_func = FN_USE;
        i_entry_id = '0;
        i_entry_bytes = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset capacity, extremes, every op, invalid id
        send_request(FN_USE, 5'd0, 32'd100);
        send_request(FN_USE, 5'd1, 32'd2000000);
        send_request(FN_LOCK, 5'd2, 32'd2000000);
        send_request(FN_USE, 5'd3, 32'd1000000);   // evicts oldest unpinned
        send_request(FN_USE, 5'd2, 32'd5);
        send_request(FN_USE, 5'd4, 32'd0);         // zero size never evicts
        send_request(FN_LOCK, 5'd3, 32'd7);
        send_request(FN_USE, 5'd31, 32'hFFFF_FFFF); // over budget
        send_request(FN_LOCK, 5'd30, 32'hFFFF_FFFF);
        send_request(FN_LOCK, 5'd29, 32'hFFFF_FFFF);
        send_request(FN_UNLOCK, 5'd2, 32'd0);
        send_request(FN_UNLOAD, 5'd31, 32'd0);
        send_request(FN_UNLOAD, 5'd31, 32'd0);
        send_request(FN_UNLOCK, 5'd7, 32'd0);
        send_request(FN_UNLOAD, 5'd0, 32'd0);
        set_capacity(32'd0);
        send_request(FN_USE, 5'd10, 32'd1);
        send_request(FN_USE, 5'd11, 32'd0);
        set_capacity(32'hFFFF_FFFF);
        send_request(FN_USE, 5'd12, 32'hFFFF_FFFF);
        send_request(FN_USE, 5'd13, 32'hFFFF_FFFF);
        // pause until every expected result is back
        drain();

        caps = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd300};
        for (int ph = 0; ph < 4; ph++) begin
            set_capacity(caps[ph]);
            for (int n = 0; n < 60; n++) begin
                logic [4:0] id;
                t_func fn;
                id = ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: fn = FN_USE;
                    5, 6: fn = FN_LOCK;
                    7, 8: fn = FN_UNLOCK;
                    default: fn = FN_UNLOAD;
                endcase
                send_request(fn, id, rand_bytes());
            end
        end
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end
endmodule
